[src/pexp_pkg.sv]
// ----------------------------------------------------------------------------
// pexp_pkg
// shared types, codes and constants of the particle explosion update block
// ----------------------------------------------------------------------------
package pexp_pkg;

    localparam int MAX_PARTICLES = 64;

    // apb register map
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_ACCEL_X = 2'd0;
    localparam logic [1:0] REG_ACCEL_Y = 2'd1;
    localparam logic [1:0] REG_ACCEL_Z = 2'd2;

    // command codes
    localparam logic CMD_SPAWN = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_TICK   = 2'd2;

    // divider geometry
    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 21;
    localparam int DIV_STEPS = 41;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] spawn_pos_x;
        logic signed [31:0] spawn_pos_y;
        logic signed [31:0] spawn_pos_z;
        logic signed [31:0] spawn_vel_x;
        logic signed [31:0] spawn_vel_y;
        logic signed [31:0] spawn_vel_z;
        logic [23:0]        spawn_size;
        logic [15:0]        spawn_green;
        logic [19:0]        spawn_energy;
        logic [15:0]        elapsed_time;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic [23:0]        out_size;
        logic [15:0]        out_green;
        logic [16:0]        out_alpha;
        logic [1:0]         status;
        logic               particle_valid;
        logic               last_item;
    } result_t;

    // one stored particle, one memory word
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [24:0] size;
        logic signed [31:0] size_rate;
        logic signed [16:0] green;
        logic signed [31:0] green_rate;
        logic signed [17:0] alpha;
        logic signed [31:0] alpha_rate;
        logic signed [21:0] energy;
    } particle_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DSIZE,
        S_DGREEN,
        S_DALPHA,
        S_RESP,
        S_TMUL,
        S_TWB,
        S_OSTART,
        S_OUT
    } state_t;

endpackage

[src/pexp_ram.sv]
// ----------------------------------------------------------------------------
// pexp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pexp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/pexp_div.sv]
// ----------------------------------------------------------------------------
// pexp_div
// restoring divider, one quotient bit per cycle, gives the negated rate
// ----------------------------------------------------------------------------
module pexp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pexp_pkg::div_req_t  req,
    output logic                done,
    output logic signed [31:0]  rate
);

    localparam int CNT_W = $clog2(pexp_pkg::DIV_STEPS + 1);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [pexp_pkg::DIV_NUM_W-1:0]   num_reg, num_next;
    logic [pexp_pkg::DIV_DEN_W-1:0]   den_reg, den_next;
    logic [pexp_pkg::DIV_DEN_W:0]     rem_reg, rem_next;
    logic [pexp_pkg::DIV_NUM_W-1:0]   quo_reg, quo_next;
    logic [pexp_pkg::DIV_DEN_W:0]     rem_sh;
    logic                             fits;

    assign rem_sh = {rem_reg[pexp_pkg::DIV_DEN_W-1:0], num_reg[pexp_pkg::DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(pexp_pkg::DIV_STEPS);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[pexp_pkg::DIV_NUM_W-2:0], fits};
            num_next = {num_reg[pexp_pkg::DIV_NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // zero divisor or quotient of 2^31 and above saturates
    assign done = done_reg;
    assign rate = ((den_reg == '0) || (quo_reg[pexp_pkg::DIV_NUM_W-1:31] != '0))
                  ? 32'sh8000_0000 : $signed((~quo_reg[31:0]) + 32'd1);

endmodule

[src/pexp_update.sv]
// ----------------------------------------------------------------------------
// pexp_update
// euler step of one particle: registered products, then add and saturate
// ----------------------------------------------------------------------------
module pexp_update (
    input  logic                 clk,
    input  pexp_pkg::particle_t  rec,
    input  logic [15:0]          dt,
    input  logic signed [31:0]   accel_x,
    input  logic signed [31:0]   accel_y,
    input  logic signed [31:0]   accel_z,
    output pexp_pkg::particle_t  upd,
    output logic                 dead
);

    logic signed [31:0] mul_a [9];
    logic signed [48:0] prod_next [9];
    logic signed [48:0] prod_reg [9];
    logic signed [33:0] energy_diff;

    function automatic logic signed [33:0] add_step(input logic signed [31:0] v,
                                                   input logic signed [48:0] p);
        return {{2{v[31]}}, v} + {p[48], p[48:16]};
    endfunction

    function automatic logic [31:0] sat_w(input logic signed [33:0] v, input int bits);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = (34'sd1 <<< (bits - 1)) - 34'sd1;
        lo = -hi - 34'sd1;
        if (v > hi)
        begin
            return hi[31:0];
        end
        else if (v < lo)
        begin
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    always_comb
    begin
        mul_a[0] = rec.vel_x;
        mul_a[1] = rec.vel_y;
        mul_a[2] = rec.vel_z;
        mul_a[3] = accel_x;
        mul_a[4] = accel_y;
        mul_a[5] = accel_z;
        mul_a[6] = rec.size_rate;
        mul_a[7] = rec.green_rate;
        mul_a[8] = rec.alpha_rate;
        for (int k = 0; k < 9; k++)
        begin
            prod_next[k] = mul_a[k] * $signed({1'b0, dt});
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign energy_diff = {{12{rec.energy[21]}}, rec.energy} - {18'd0, dt};

    always_comb
    begin
        upd            = rec;
        upd.pos_x      = sat_w(add_step(rec.pos_x, prod_reg[0]), 32);
        upd.pos_y      = sat_w(add_step(rec.pos_y, prod_reg[1]), 32);
        upd.pos_z      = sat_w(add_step(rec.pos_z, prod_reg[2]), 32);
        upd.vel_x      = sat_w(add_step(rec.vel_x, prod_reg[3]), 32);
        upd.vel_y      = sat_w(add_step(rec.vel_y, prod_reg[4]), 32);
        upd.vel_z      = sat_w(add_step(rec.vel_z, prod_reg[5]), 32);
        upd.size       = 25'(sat_w(add_step({{7{rec.size[24]}}, rec.size}, prod_reg[6]), 25));
        upd.green      = 17'(sat_w(add_step({{15{rec.green[16]}}, rec.green}, prod_reg[7]), 17));
        upd.alpha      = 18'(sat_w(add_step({{14{rec.alpha[17]}}, rec.alpha}, prod_reg[8]), 18));
        upd.energy     = 22'(sat_w(energy_diff, 22));
    end

    assign dead = upd.energy[21] || (upd.energy == '0);

endmodule

[src/particle_explosion_update.sv]
// ----------------------------------------------------------------------------
// particle_explosion_update
// explosion particle store with fixed point euler update and survivor stream
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid/item_ready/item): one beat is a spawn or a tick
//   result channel (result_valid/result_ready/result): spawn gives one beat,
//     a tick gives one beat per survivor in store order, or a single empty
//     beat when nothing survives; last_item marks the final beat
//   apb port sets accel_x/y/z at 0x0/0x4/0x8, write only while idle
// timing
//   spawn: three quotients, size, green and alpha in turn, from one shared
//     restoring divider, then the result beat
//   tick: each particle is visited once (memory read + multiply, then
//     add/saturate/write back), a death pulls the last entry into its
//     slot; then S_OSTART and one beat per cycle while the receiver takes them
//   one item at a time: item_ready is high only while idle
// reset clears the particle count, the accelerations and all handshakes;
//   the particle memory is not cleared, only entries below the count are read
// a stalled receiver holds the result register and freezes the stream
// ----------------------------------------------------------------------------
module particle_explosion_update #(
    parameter int MAX_PARTICLES = pexp_pkg::MAX_PARTICLES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  pexp_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output pexp_pkg::result_t                 result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pexp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int RW = $bits(pexp_pkg::particle_t);

    pexp_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       live_reg, live_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [15:0]         dt_reg, dt_next;
    pexp_pkg::item_t     spawn_reg, spawn_next;
    logic signed [31:0]  size_rate_reg, size_rate_next;
    logic signed [31:0]  green_rate_reg, green_rate_next;
    logic [1:0]          status_reg, status_next;
    logic signed [31:0]  accel_x_reg, accel_y_reg, accel_z_reg;
    pexp_pkg::result_t   result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic                accept;
    logic                full;
    logic                out_free;
    logic                cfg_write;
    logic [CW-1:0]       cnt_dec;
    logic [CW-1:0]       idx_inc;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    pexp_pkg::particle_t ram_wdata;
    pexp_pkg::particle_t ram_rdata;
    pexp_pkg::particle_t new_rec;
    pexp_pkg::particle_t upd_rec;
    logic                upd_dead;

    pexp_pkg::div_req_t  div_req;
    logic                div_done;
    logic signed [31:0]  div_rate;

    assign item_ready = (state_reg == pexp_pkg::S_IDLE);
    assign accept     = item_valid && item_ready;
    assign full       = live_reg >= CW'(MAX_PARTICLES);
    assign out_free   = !result_valid_reg || result_ready;
    assign cnt_dec    = cnt_reg - CW'(1);
    assign idx_inc    = idx_reg + CW'(1);

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_x_reg <= '0;
            accel_y_reg <= '0;
            accel_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                pexp_pkg::REG_ACCEL_X: accel_x_reg <= pwdata;
                pexp_pkg::REG_ACCEL_Y: accel_y_reg <= pwdata;
                pexp_pkg::REG_ACCEL_Z: accel_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pexp_pkg::REG_ACCEL_X: prdata = accel_x_reg;
            pexp_pkg::REG_ACCEL_Y: prdata = accel_y_reg;
            pexp_pkg::REG_ACCEL_Z: prdata = accel_z_reg;
            default:               prdata = '0;
        endcase
    end

    // ---------------- particle memory ----------------
    // read address comes from rd_addr_next so data shows in the cycle after
    // the address is chosen; a tick never reads the slot it writes in the
    // same cycle (reads go to later slots), and the stream start waits in
    // S_OSTART after the last write back
    pexp_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_next),
        .rdata (ram_rdata)
    );

    // ---------------- shared divider for the spawn rates ----------------
    pexp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .rate  (div_rate)
    );

    // ---------------- euler step datapath ----------------
    pexp_update u_update (
        .clk     (clk),
        .rec     (ram_rdata),
        .dt      (dt_reg),
        .accel_x (accel_x_reg),
        .accel_y (accel_y_reg),
        .accel_z (accel_z_reg),
        .upd     (upd_rec),
        .dead    (upd_dead)
    );

    // new particle record, alpha starts at one
    always_comb
    begin
        new_rec            = '0;
        new_rec.pos_x      = spawn_reg.spawn_pos_x;
        new_rec.pos_y      = spawn_reg.spawn_pos_y;
        new_rec.pos_z      = spawn_reg.spawn_pos_z;
        new_rec.vel_x      = spawn_reg.spawn_vel_x;
        new_rec.vel_y      = spawn_reg.spawn_vel_y;
        new_rec.vel_z      = spawn_reg.spawn_vel_z;
        new_rec.size       = {1'b0, spawn_reg.spawn_size};
        new_rec.size_rate  = size_rate_reg;
        new_rec.green      = {1'b0, spawn_reg.spawn_green};
        new_rec.green_rate = green_rate_reg;
        new_rec.alpha      = 18'sd65536;
        new_rec.alpha_rate = div_rate;
        new_rec.energy     = {2'b00, spawn_reg.spawn_energy};
    end

    // divider operands: size<<16/e, green<<16/(2e), 2^32/e in that order
    always_comb
    begin
        case (state_reg)
            pexp_pkg::S_DSIZE:
            begin
                div_req.num = {9'd0, spawn_reg.spawn_green, 16'd0};
                div_req.den = {spawn_reg.spawn_energy, 1'b0};
            end
            pexp_pkg::S_DGREEN:
            begin
                div_req.num = {9'd1, 32'd0};
                div_req.den = {1'b0, spawn_reg.spawn_energy};
            end
            default:
            begin
                div_req.num = {1'b0, item.spawn_size, 16'd0};
                div_req.den = {1'b0, item.spawn_energy};
            end
        endcase
        div_req.start = (accept && (item.cmd == pexp_pkg::CMD_SPAWN) && !full)
                     || (div_done && (state_reg == pexp_pkg::S_DSIZE))
                     || (div_done && (state_reg == pexp_pkg::S_DGREEN));
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pexp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == pexp_pkg::CMD_TICK)
                    begin
                        state_next = (live_reg == '0) ? pexp_pkg::S_RESP : pexp_pkg::S_TMUL;
                    end
                    else
                    begin
                        state_next = full ? pexp_pkg::S_RESP : pexp_pkg::S_DSIZE;
                    end
                end
            end
            pexp_pkg::S_DSIZE:
            begin
                if (div_done)
                begin
                    state_next = pexp_pkg::S_DGREEN;
                end
            end
            pexp_pkg::S_DGREEN:
            begin
                if (div_done)
                begin
                    state_next = pexp_pkg::S_DALPHA;
                end
            end
            pexp_pkg::S_DALPHA:
            begin
                if (div_done)
                begin
                    state_next = pexp_pkg::S_RESP;
                end
            end
            pexp_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = pexp_pkg::S_IDLE;
                end
            end
            pexp_pkg::S_TMUL:
            begin
                state_next = pexp_pkg::S_TWB;
            end
            pexp_pkg::S_TWB:
            begin
                if (upd_dead)
                begin
                    if (idx_reg < cnt_dec)
                    begin
                        state_next = pexp_pkg::S_TMUL;
                    end
                    else
                    begin
                        state_next = (cnt_dec == '0) ? pexp_pkg::S_RESP : pexp_pkg::S_OSTART;
                    end
                end
                else
                begin
                    state_next = (idx_inc < cnt_reg) ? pexp_pkg::S_TMUL : pexp_pkg::S_OSTART;
                end
            end
            pexp_pkg::S_OSTART:
            begin
                state_next = pexp_pkg::S_OUT;
            end
            pexp_pkg::S_OUT:
            begin
                if (out_free && (idx_inc == live_reg))
                begin
                    state_next = pexp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pexp_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- datapath control ----------------
    always_comb
    begin
        live_next         = live_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        rd_addr_next      = rd_addr_reg;
        dt_next           = dt_reg;
        spawn_next        = spawn_reg;
        size_rate_next    = size_rate_reg;
        green_rate_next   = green_rate_reg;
        status_next       = status_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg[AW-1:0];
        ram_wdata         = upd_rec;
        case (state_reg)
            pexp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    spawn_next   = item;
                    dt_next      = item.elapsed_time;
                    cnt_next     = live_reg;
                    idx_next     = '0;
                    rd_addr_next = '0;
                    if (item.cmd == pexp_pkg::CMD_TICK)
                    begin
                        status_next = pexp_pkg::ST_TICK;
                    end
                    else
                    begin
                        status_next = full ? pexp_pkg::ST_FULL : pexp_pkg::ST_ACCEPT;
                    end
                end
            end
            pexp_pkg::S_DSIZE:
            begin
                if (div_done)
                begin
                    size_rate_next = div_rate;
                end
            end
            pexp_pkg::S_DGREEN:
            begin
                if (div_done)
                begin
                    green_rate_next = div_rate;
                end
            end
            pexp_pkg::S_DALPHA:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = live_reg[AW-1:0];
                    ram_wdata = new_rec;
                    live_next = live_reg + CW'(1);
                end
            end
            pexp_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    result_next           = '0;
                    result_next.status    = status_reg;
                    result_next.last_item = 1'b1;
                    result_valid_next     = 1'b1;
                end
            end
            pexp_pkg::S_TWB:
            begin
                if (upd_dead)
                begin
                    // last live entry moves into this slot and is stepped there
                    cnt_next     = cnt_dec;
                    rd_addr_next = cnt_dec[AW-1:0];
                    if (!(idx_reg < cnt_dec))
                    begin
                        live_next = cnt_dec;
                    end
                end
                else
                begin
                    ram_we       = 1'b1;
                    idx_next     = idx_inc;
                    rd_addr_next = idx_inc[AW-1:0];
                    if (!(idx_inc < cnt_reg))
                    begin
                        live_next = cnt_reg;
                    end
                end
            end
            pexp_pkg::S_OSTART:
            begin
                idx_next     = '0;
                rd_addr_next = '0;
            end
            pexp_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    result_next.out_pos_x      = ram_rdata.pos_x;
                    result_next.out_pos_y      = ram_rdata.pos_y;
                    result_next.out_pos_z      = ram_rdata.pos_z;
                    result_next.out_size       = ram_rdata.size[24] ? '0 : ram_rdata.size[23:0];
                    result_next.out_green      = ram_rdata.green[16] ? '0 : ram_rdata.green[15:0];
                    result_next.out_alpha      = ram_rdata.alpha[17] ? '0 : ram_rdata.alpha[16:0];
                    result_next.status         = pexp_pkg::ST_TICK;
                    result_next.particle_valid = 1'b1;
                    result_next.last_item      = (idx_inc == live_reg);
                    result_valid_next          = 1'b1;
                    idx_next                   = idx_inc;
                    rd_addr_next               = idx_inc[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pexp_pkg::S_IDLE;
            live_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            live_reg         <= live_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        rd_addr_reg    <= rd_addr_next;
        dt_reg         <= dt_next;
        spawn_reg      <= spawn_next;
        size_rate_reg  <= size_rate_next;
        green_rate_reg <= green_rate_next;
        status_reg     <= status_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // particle count never runs past the store
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(MAX_PARTICLES))
        else $error("particle count beyond store depth");

    // the stream only reads entries below the live count
    a_stream_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pexp_pkg::S_OUT) |-> (idx_reg < live_reg))
        else $error("stream index beyond live count");

    // a quotient only finishes while a spawn waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == pexp_pkg::S_DSIZE) || (state_reg == pexp_pkg::S_DGREEN)
                      || (state_reg == pexp_pkg::S_DALPHA)))
        else $error("divider finished outside a spawn");

    // a spawn that is stored bumps the count by one
    a_spawn_count: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done && (state_reg == pexp_pkg::S_DALPHA)) |=> (live_reg == $past(live_reg) + CW'(1)))
        else $error("spawn did not bump the count");
`endif

endmodule

[sim/tb_particle_explosion_update.sv]
// ----------------------------------------------------------------------------
// tb_particle_explosion_update
// checks spawn, tick, store-full and survivor streaming against a local
// fixed point predictor, under random bursts, gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_particle_explosion_update;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 20000;
    localparam int NP = pexp_pkg::MAX_PARTICLES;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    pexp_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pexp_pkg::result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pexp_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    particle_explosion_update dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state, kept wide so saturation is explicit
    longint acc_x, acc_y, acc_z;
    int unsigned live_n;
    longint ppx[NP], ppy[NP], ppz[NP];
    longint pvx[NP], pvy[NP], pvz[NP];
    longint psz[NP], psr[NP];
    longint pgr[NP], pgrr[NP];
    longint pal[NP], palr[NP];
    longint pen[NP];

    pexp_pkg::item_t pending_items[$];
    pexp_pkg::result_t expected_beats[$];
    int mismatches = 0;
    bit hold_items = 1'b0;
    int wdog = 0;

    function automatic longint sat(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // floor division by 2^16 is an arithmetic shift on signed values
    function automatic longint advance(longint v, longint rate, longint dt, int bits);
        return sat(v + ((rate * dt) >>> 16), bits);
    endfunction

    function automatic longint decay_rate(longint num, longint den);
        longint q;
        if (den == 0)
            return -(longint'(1) << 31);
        q = num / den;
        if (q > (longint'(1) << 31))
            q = longint'(1) << 31;
        return -q;
    endfunction

    function automatic pexp_pkg::result_t survivor_beat(int unsigned i, bit last);
        pexp_pkg::result_t r;
        r = '0;
        r.out_pos_x = ppx[i][31:0];
        r.out_pos_y = ppy[i][31:0];
        r.out_pos_z = ppz[i][31:0];
        r.out_size = psz[i] < 0 ? '0 : psz[i][23:0];
        r.out_green = pgr[i] < 0 ? '0 : pgr[i][15:0];
        r.out_alpha = pal[i] < 0 ? '0 : pal[i][16:0];
        r.status = pexp_pkg::ST_TICK;
        r.particle_valid = 1'b1;
        r.last_item = last;
        return r;
    endfunction

    task automatic predict_particles(input pexp_pkg::item_t it);
        pexp_pkg::result_t r;
        longint dt;
        int unsigned i;
        int unsigned d;
        r = '0;
        r.last_item = 1'b1;
        if (it.cmd == pexp_pkg::CMD_SPAWN)
        begin
            if (live_n >= NP)
            begin
                r.status = pexp_pkg::ST_FULL;
            end
            else
            begin
                i = live_n;
                ppx[i] = it.spawn_pos_x; ppy[i] = it.spawn_pos_y; ppz[i] = it.spawn_pos_z;
                pvx[i] = it.spawn_vel_x; pvy[i] = it.spawn_vel_y; pvz[i] = it.spawn_vel_z;
                psz[i] = it.spawn_size;
                pgr[i] = it.spawn_green;
                pal[i] = 65536;
                pen[i] = it.spawn_energy;
                psr[i] = decay_rate(longint'(it.spawn_size) << 16, it.spawn_energy);
                pgrr[i] = decay_rate(longint'(it.spawn_green) << 16,
                                     longint'(it.spawn_energy) << 1);
                palr[i] = decay_rate(longint'(1) << 32, it.spawn_energy);
                live_n++;
                r.status = pexp_pkg::ST_ACCEPT;
            end
            expected_beats.push_back(r);
            return;
        end
        dt = it.elapsed_time;
        i = 0;
        while (i < live_n)
        begin
            ppx[i] = advance(ppx[i], pvx[i], dt, 32);
            ppy[i] = advance(ppy[i], pvy[i], dt, 32);
            ppz[i] = advance(ppz[i], pvz[i], dt, 32);
            pvx[i] = advance(pvx[i], acc_x, dt, 32);
            pvy[i] = advance(pvy[i], acc_y, dt, 32);
            pvz[i] = advance(pvz[i], acc_z, dt, 32);
            pen[i] = sat(pen[i] - dt, 22);
            psz[i] = advance(psz[i], psr[i], dt, 25);
            pal[i] = advance(pal[i], palr[i], dt, 18);
            pgr[i] = advance(pgr[i], pgrr[i], dt, 17);
            if (pen[i] <= 0)
            begin
                // dead: last entry moves into this slot and is updated here
                live_n--;
                d = live_n;
                ppx[i] = ppx[d]; ppy[i] = ppy[d]; ppz[i] = ppz[d];
                pvx[i] = pvx[d]; pvy[i] = pvy[d]; pvz[i] = pvz[d];
                psz[i] = psz[d]; psr[i] = psr[d]; pgr[i] = pgr[d]; pgrr[i] = pgrr[d];
                pal[i] = pal[d]; palr[i] = palr[d]; pen[i] = pen[d];
            end
            else
            begin
                i++;
            end
        end
        if (live_n == 0)
        begin
            r.status = pexp_pkg::ST_TICK;
            expected_beats.push_back(r);
        end
        else
        begin
            for (i = 0; i < live_n; i++)
                expected_beats.push_back(survivor_beat(i, i + 1 == live_n));
        end
    endtask

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predict_particles(item);
                void'(pending_items.pop_front());
            end
            if (item_valid && !item_ready)
            begin
                // hold the beat
            end
            else if (hold_items || pending_items.size() == 0)
            begin
                item_valid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else
            begin
                item_valid <= 1'b1;
                item <= pending_items[0];
                if (burst_left <= 1)
                begin
                    burst_left <= int'($urandom_range(1, 8));
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern: calm stretches and choppy stretches
    int stall_phase = 0;
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[8])
            result_ready <= 1'b1;
        else if (stall_phase[7])
            result_ready <= ($urandom_range(0, 3) != 0);
        else
            result_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (result_valid && result_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", result);
                end
                else
                begin
                    if (result !== expected_beats[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat mismatch exp %p act %p", expected_beats[0], result);
                    end
                    void'(expected_beats.pop_front());
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= pexp_pkg::APB_ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            pexp_pkg::REG_ACCEL_X: acc_x = longint'(signed'(val));
            pexp_pkg::REG_ACCEL_Y: acc_y = longint'(signed'(val));
            default:               acc_z = longint'(signed'(val));
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic pexp_pkg::item_t spawn_item(logic [31:0] p, logic [31:0] v,
                                                   logic [23:0] s, logic [15:0] g,
                                                   logic [19:0] e);
        pexp_pkg::item_t it;
        it = '0;
        it.cmd = pexp_pkg::CMD_SPAWN;
        it.spawn_pos_x = p; it.spawn_pos_y = ~p; it.spawn_pos_z = p ^ 32'h5a5a_a5a5;
        it.spawn_vel_x = v; it.spawn_vel_y = -v; it.spawn_vel_z = v ^ 32'hffff_0000;
        it.spawn_size = s; it.spawn_green = g; it.spawn_energy = e;
        return it;
    endfunction

    function automatic pexp_pkg::item_t tick_item(logic [15:0] dt);
        pexp_pkg::item_t it;
        it = '0;
        it.cmd = pexp_pkg::CMD_TICK;
        it.elapsed_time = dt;
        return it;
    endfunction

    function automatic pexp_pkg::item_t random_item();
        pexp_pkg::item_t it;
        it = spawn_item($urandom, $urandom, 24'($urandom), 16'($urandom),
                        20'($urandom_range(1, 20'hfffff)));
        it.spawn_pos_y = $urandom; it.spawn_vel_z = $urandom;
        if ($urandom_range(0, 3) == 0)
            it.spawn_energy = 20'($urandom_range(1, 20'h1ffff));
        it.elapsed_time = 16'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            it.cmd = pexp_pkg::CMD_TICK;
            // mostly short ticks so particles live a few rounds
            if ($urandom_range(0, 3) != 0)
                it.elapsed_time = 16'($urandom_range(0, 16'h3fff));
        end
        return it;
    endfunction

    initial
    begin
        acc_x = 0; acc_y = 0; acc_z = 0; live_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        apb_write(pexp_pkg::REG_ACCEL_X, 32'h7fff_ffff);
        apb_write(pexp_pkg::REG_ACCEL_Y, 32'h8000_0000);
        apb_write(pexp_pkg::REG_ACCEL_Z, 32'h0000_0000);

        // directed: empty tick, field extremes, zero elapsed time, saturation
        pending_items.push_back(tick_item(16'h0000));
        pending_items.push_back(spawn_item(32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff,
                                           16'hffff, 20'hfffff));
        pending_items.push_back(spawn_item(32'h8000_0000, 32'h8000_0000, 24'h0,
                                           16'h0, 20'h00001));
        pending_items.push_back(spawn_item(32'h0, 32'h0001_0000, 24'h01_0000,
                                           16'h8000, 20'h1_0000));
        pending_items.push_back(tick_item(16'h0000));
        pending_items.push_back(tick_item(16'hffff));
        pending_items.push_back(tick_item(16'h8000));
        pending_items.push_back(tick_item(16'hffff));
        wait_drained();

        apb_write(pexp_pkg::REG_ACCEL_X, 32'h8000_0000);
        apb_write(pexp_pkg::REG_ACCEL_Y, 32'h7fff_ffff);
        apb_write(pexp_pkg::REG_ACCEL_Z, 32'hfffe_0000);
        // fill the store, then the spawns beyond it are reported full
        for (int k = 0; k < NP + 2; k++)
            pending_items.push_back(spawn_item($urandom, $urandom, 24'($urandom),
                                               16'($urandom), 20'hfffff));
        pending_items.push_back(tick_item(16'h1000));
        pending_items.push_back(tick_item(16'hffff));
        wait_drained();

        // random part in phases with fresh accelerations
        for (int ph = 0; ph < 4; ph++)
        begin
            apb_write(pexp_pkg::REG_ACCEL_X, $urandom);
            apb_write(pexp_pkg::REG_ACCEL_Y, (ph == 3) ? 32'h0 : $urandom);
            apb_write(pexp_pkg::REG_ACCEL_Z, $urandom_range(0, 32'h0004_0000));
            for (int k = 0; k < 5; k++)
                pending_items.push_back(random_item());
            pending_items.push_back(tick_item(16'($urandom)));
            if (ph == 1)
            begin
                // sender pauses until every expected beat has arrived
                while (pending_items.size() > 3)
                    @(posedge clk);
                hold_items = 1'b1;
                while (item_valid || expected_beats.size() != 0)
                    @(posedge clk);
                hold_items = 1'b0;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        wait (wdog >= WDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule
